>>> design/gcf_pkg.sv
package gcf_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 31;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 2'd3;

  localparam logic signed [31:0] ONE_Q30     = 32'sh40000000;
  localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC0000000;
  localparam logic signed [65:0] ONE_Q60     = 66'sd1152921504606846976;
  // 0.05 in Q0.32
  localparam logic [27:0]        ROT_DAMP    = 28'd214748365;

  typedef struct packed {
    logic signed [31:0] height;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] ground_height;
  } gcf_in_t;

  typedef struct packed {
    logic               contact;
    logic [30:0]        depth;
    logic signed [31:0] force_x;
    logic [30:0]        force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } gcf_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] radius;
    logic [CFG_W-1:0] stiff;
    logic [CFG_W-1:0] damp;
    logic [CFG_W-1:0] mu;
  } gcf_cfg_t;

  // per-transaction values that ride alongside the long datapath
  typedef struct packed {
    logic               valid;
    logic               contact;
    logic [30:0]        depth;
    logic [30:0]        fn;
    logic [45:0]        coul;
    logic               fric_en;
    logic signed [31:0] vx;
    logic signed [31:0] vz;
    logic signed [31:0] tq_x;
    logic signed [31:0] tq_y;
    logic signed [31:0] tq_z;
  } gcf_side_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] x);
    if (x > ONE_Q30) return ONE_Q30;
    if (x < NEG_ONE_Q30) return NEG_ONE_Q30;
    return x;
  endfunction

  // floor Q4.60 to Q2.30, then clamp to +-1.0
  function automatic logic signed [31:0] clamp_e(input logic signed [65:0] m);
    logic signed [65:0] s;
    s = m >>> 30;
    if (s > 66'sd1073741824) return ONE_Q30;
    if (s < -66'sd1073741824) return NEG_ONE_Q30;
    return 32'(s);
  endfunction

  // result = neg ? -mag : mag, saturated to 32-bit signed
  function automatic logic signed [31:0] opp_sat(input logic neg, input logic [47:0] mag);
    if (neg) begin
      if (mag > 48'd2147483648) return 32'sh80000000;
      return 32'(-$signed({1'b0, mag}));
    end
    if (mag > 48'd2147483647) return 32'sh7fffffff;
    return $signed(mag[31:0]);
  endfunction

endpackage

>>> design/gcf_sqrt.sv
module gcf_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  logic [63:0] n_r   [gcf_pkg::SQRT_STAGES];
  logic [63:0] res_r [gcf_pkg::SQRT_STAGES];

  // one result bit per stage, trial bit walking down from 2^62
  for (genvar i = 0; i < gcf_pkg::SQRT_STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] n_prev;
    logic [63:0] res_prev;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign n_prev   = n_i;
      assign res_prev = '0;
    end else begin : g_next
      assign n_prev   = n_r[i-1];
      assign res_prev = res_r[i-1];
    end

    assign trial = res_prev + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_prev >= trial) begin
          n_r[i]   <= n_prev - trial;
          res_r[i] <= (res_prev >> 1) + BIT;
        end else begin
          n_r[i]   <= n_prev;
          res_r[i] <= res_prev >> 1;
        end
      end
    end
  end

  assign root_o = res_r[gcf_pkg::SQRT_STAGES-1][31:0];

endmodule

>>> design/gcf_div.sv
module gcf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] num_i,
  input  logic [31:0] den_i,
  output logic [29:0] quo_o
);

  logic [61:0] rem_r [gcf_pkg::DIV_STAGES];
  logic [31:0] den_r [gcf_pkg::DIV_STAGES];
  logic [29:0] quo_r [gcf_pkg::DIV_STAGES];

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < gcf_pkg::DIV_STAGES; i++) begin : g_stage
    localparam int POS = gcf_pkg::DIV_STAGES - 1 - i;
    logic [61:0] rem_prev;
    logic [31:0] den_prev;
    logic [29:0] quo_prev;
    logic [61:0] shifted;

    if (i == 0) begin : g_first
      assign rem_prev = num_i;
      assign den_prev = den_i;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[i-1];
      assign den_prev = den_r[i-1];
      assign quo_prev = quo_r[i-1];
    end

    assign shifted = {30'd0, den_prev} << POS;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_prev;
        if (rem_prev >= shifted) begin
          rem_r[i] <= rem_prev - shifted;
          quo_r[i] <= quo_prev | (30'd1 << POS);
        end else begin
          rem_r[i] <= rem_prev;
          quo_r[i] <= quo_prev;
        end
      end
    end
  end

  assign quo_o = quo_r[gcf_pkg::DIV_STAGES-1];

endmodule

>>> design/gcf_front.sv
module gcf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  gcf_pkg::gcf_in_t    in_data,
  input  gcf_pkg::gcf_cfg_t   cfg,
  output logic [63:0]         sum_o,
  output gcf_pkg::gcf_side_t  side_o
);

  // stage 1: penetration, normal products, speed squares, quaternion products
  logic signed [34:0] pen;
  logic signed [41:0] pen100;
  logic signed [31:0] qw, qx, qy, qz;
  logic [30:0]        depth_nxt;
  logic signed [63:0] qq_nxt [9];

  logic               v1_r;
  logic               contact1_r;
  logic [30:0]        depth1_r;
  logic signed [66:0] kp1_r;
  logic signed [63:0] dvy1_r;
  logic signed [63:0] vx2_1_r, vz2_1_r;
  logic signed [63:0] qq1_r [9];
  logic signed [31:0] vx1_r, vz1_r;
  logic signed [31:0] rate1_r [3];

  always_comb begin
    pen = 35'(in_data.ground_height) + $signed({4'd0, cfg.radius}) - 35'(in_data.height);
    pen100 = 42'(pen) * 42'sd100;
    if (pen[34]) depth_nxt = '0;
    else if (pen[33:31] != 3'd0) depth_nxt = '1;
    else depth_nxt = pen[30:0];
    qw = gcf_pkg::clamp_q30(in_data.quat_w);
    qx = gcf_pkg::clamp_q30(in_data.quat_x);
    qy = gcf_pkg::clamp_q30(in_data.quat_y);
    qz = gcf_pkg::clamp_q30(in_data.quat_z);
    // xx yy zz xy wz xz wy yz wx
    qq_nxt[0] = qx * qx;
    qq_nxt[1] = qy * qy;
    qq_nxt[2] = qz * qz;
    qq_nxt[3] = qx * qy;
    qq_nxt[4] = qw * qz;
    qq_nxt[5] = qx * qz;
    qq_nxt[6] = qw * qy;
    qq_nxt[7] = qy * qz;
    qq_nxt[8] = qw * qx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      contact1_r <= pen100 >= -42'sd32768;
      depth1_r   <= depth_nxt;
      kp1_r      <= pen * $signed({1'b0, cfg.stiff});
      dvy1_r     <= $signed({1'b0, cfg.damp}) * in_data.vel_y;
      vx2_1_r    <= in_data.vel_x * in_data.vel_x;
      vz2_1_r    <= in_data.vel_z * in_data.vel_z;
      for (int i = 0; i < 9; i++) qq1_r[i] <= qq_nxt[i];
      vx1_r      <= in_data.vel_x;
      vz1_r      <= in_data.vel_z;
      rate1_r[0] <= in_data.rate_x;
      rate1_r[1] <= in_data.rate_y;
      rate1_r[2] <= in_data.rate_z;
    end
  end

  // stage 2: normal force, speed sum, rotation matrix
  localparam logic signed [65:0] ONE_Q60_L = gcf_pkg::ONE_Q60;

  logic signed [66:0] fn_full;
  logic signed [66:0] fn_shr;
  logic [30:0]        fn_nxt;
  logic [63:0]        sum_nxt;
  logic signed [65:0] m [9];
  gcf_pkg::gcf_side_t side2_nxt;

  gcf_pkg::gcf_side_t side2_r;
  logic [63:0]        sum2_r;
  logic signed [31:0] e2_r [9];
  logic signed [31:0] rate2_r [3];

  always_comb begin
    fn_full = kp1_r - 67'(dvy1_r);
    fn_shr  = fn_full >>> 16;
    if (fn_shr[66]) fn_nxt = '0;
    else if (fn_shr[65:31] != '0) fn_nxt = '1;
    else fn_nxt = fn_shr[30:0];
    sum_nxt = $unsigned(vx2_1_r) + $unsigned(vz2_1_r);

    m[0] = ONE_Q60_L - ((66'(qq1_r[1]) + 66'(qq1_r[2])) <<< 1);
    m[1] = (66'(qq1_r[3]) - 66'(qq1_r[4])) <<< 1;
    m[2] = (66'(qq1_r[5]) + 66'(qq1_r[6])) <<< 1;
    m[3] = (66'(qq1_r[3]) + 66'(qq1_r[4])) <<< 1;
    m[4] = ONE_Q60_L - ((66'(qq1_r[0]) + 66'(qq1_r[2])) <<< 1);
    m[5] = (66'(qq1_r[7]) - 66'(qq1_r[8])) <<< 1;
    m[6] = (66'(qq1_r[5]) - 66'(qq1_r[6])) <<< 1;
    m[7] = (66'(qq1_r[7]) + 66'(qq1_r[8])) <<< 1;
    m[8] = ONE_Q60_L - ((66'(qq1_r[0]) + 66'(qq1_r[1])) <<< 1);

    side2_nxt         = '0;
    side2_nxt.valid   = v1_r;
    side2_nxt.contact = contact1_r;
    side2_nxt.depth   = depth1_r;
    side2_nxt.fn      = fn_nxt;
    side2_nxt.fric_en = (sum_nxt != 64'd0) && (fn_nxt != 31'd0);
    side2_nxt.vx      = vx1_r;
    side2_nxt.vz      = vz1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2_r <= sum_nxt;
      for (int i = 0; i < 9; i++) e2_r[i] <= gcf_pkg::clamp_e(m[i]);
      for (int i = 0; i < 3; i++) rate2_r[i] <= rate1_r[i];
    end
  end

  // stage 3: Coulomb limit, torque scale, matrix times rate
  logic [61:0]        coul_p;
  logic [58:0]        rot_p;
  gcf_pkg::gcf_side_t side3_nxt;

  gcf_pkg::gcf_side_t side3_r;
  logic [26:0]        rot3_r;
  logic signed [63:0] pe3_r [9];

  always_comb begin
    coul_p = cfg.mu * side2_r.fn;
    rot_p  = side2_r.fn * gcf_pkg::ROT_DAMP;
    side3_nxt      = side2_r;
    side3_nxt.coul = coul_p[61:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot3_r <= rot_p[58:32];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pe3_r[3*r+c] <= e2_r[3*r+c] * rate2_r[c];
        end
      end
    end
  end

  // stage 4: world rate
  logic signed [65:0] wsum [3];

  gcf_pkg::gcf_side_t side4_r;
  logic [26:0]        rot4_r;
  logic signed [35:0] wrl4_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wsum[i] = 66'(pe3_r[3*i]) + 66'(pe3_r[3*i+1]) + 66'(pe3_r[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot4_r <= rot3_r;
      for (int i = 0; i < 3; i++) wrl4_r[i] <= 36'(wsum[i] >>> 30);
    end
  end

  // stage 5: magnitude times scale
  logic signed [35:0] wmag [3];

  gcf_pkg::gcf_side_t side5_r;
  logic [61:0]        tp5_r [3];
  logic               neg5_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wmag[i] = wrl4_r[i][35] ? -wrl4_r[i] : wrl4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tp5_r[i]  <= $unsigned(wmag[i][34:0]) * rot4_r;
        neg5_r[i] <= wrl4_r[i] > 36'sd0;
      end
    end
  end

  // stage 6: oppose and saturate
  gcf_pkg::gcf_side_t side6_nxt;
  gcf_pkg::gcf_side_t side6_r;

  always_comb begin
    side6_nxt      = side5_r;
    side6_nxt.tq_x = gcf_pkg::opp_sat(neg5_r[0], {2'd0, tp5_r[0][61:16]});
    side6_nxt.tq_y = gcf_pkg::opp_sat(neg5_r[1], {2'd0, tp5_r[1][61:16]});
    side6_nxt.tq_z = gcf_pkg::opp_sat(neg5_r[2], {2'd0, tp5_r[2][61:16]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r <= '0;
      side3_r <= '0;
      side4_r <= '0;
      side5_r <= '0;
      side6_r <= '0;
    end else if (en) begin
      side2_r <= side2_nxt;
      side3_r <= side3_nxt;
      side4_r <= side3_r;
      side5_r <= side4_r;
      side6_r <= side6_nxt;
    end
  end

  assign sum_o  = sum2_r;
  assign side_o = side6_r;

endmodule

>>> design/ground_contact_force_core.sv
// Ground contact force core. Takes one body state per cycle and returns the
// contact flag, depth, spring-damper normal force, Coulomb/viscous friction and
// rotational damping torque, all Q16.16 and saturated. One transaction is
// accepted every cycle while the output side keeps up; a stalled output holds
// the whole pipeline. The pipeline's length is set by the planar-speed square
// root (32 stages, one root bit each) and the friction ratio divider (30
// stages, one quotient bit each). Registers are written through the cfg port;
// the user must write them only while no transaction is in flight, which the
// block itself does not enforce.
module ground_contact_force_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gcf_pkg::gcf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gcf_pkg::gcf_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [gcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcf_pkg::CFG_W-1:0]           cfg_wdata
);

  // side line index j holds the transaction at pipeline stage 7 + j
  localparam int SIDE_VISC = gcf_pkg::SQRT_STAGES - 4;
  localparam int SIDE_DIVQ = SIDE_VISC + 1 + gcf_pkg::DIV_STAGES;
  localparam int SIDE_LEN  = SIDE_DIVQ + 2;

  gcf_pkg::gcf_cfg_t  cfg_r;
  logic               en;
  logic [63:0]        fr_sum;
  gcf_pkg::gcf_side_t fr_side;
  logic [31:0]        vt;
  logic [29:0]        quo;

  gcf_pkg::gcf_side_t side_r [SIDE_LEN];
  logic               out_valid_r;
  gcf_pkg::gcf_out_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcf_pkg::CFG_RADIUS:   cfg_r.radius <= cfg_wdata;
        gcf_pkg::CFG_STIFF:    cfg_r.stiff  <= cfg_wdata;
        gcf_pkg::CFG_DAMP:     cfg_r.damp   <= cfg_wdata;
        gcf_pkg::CFG_FRICTION: cfg_r.mu     <= cfg_wdata;
      endcase
    end
  end

  // advance everything together; hold on an output stall
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  gcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .sum_o    (fr_sum),
    .side_o   (fr_side)
  );

  gcf_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .n_i    (fr_sum),
    .root_o (vt)
  );

  // viscous term, then the smaller of the two limits into the divider
  logic [62:0] visc_p;
  logic [45:0] visc_r;
  logic [31:0] vt35_r;
  logic [45:0] dyn;
  logic [61:0] num_r;
  logic [31:0] den_r;

  always_comb begin
    visc_p = cfg_r.damp * vt;
    dyn = (side_r[SIDE_VISC].coul < visc_r) ? side_r[SIDE_VISC].coul : visc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visc_r <= visc_p[62:17];
      vt35_r <= vt;
      num_r  <= {dyn, 16'd0};
      den_r  <= vt35_r;
    end
  end

  gcf_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num_r),
    .den_i (den_r),
    .quo_o (quo)
  );

  // friction components
  logic [31:0] absx, absz;
  logic [61:0] px_r, pz_r;
  logic        negx_r, negz_r;

  always_comb begin
    absx = side_r[SIDE_DIVQ].vx[31] ? 32'(-side_r[SIDE_DIVQ].vx) : 32'(side_r[SIDE_DIVQ].vx);
    absz = side_r[SIDE_DIVQ].vz[31] ? 32'(-side_r[SIDE_DIVQ].vz) : 32'(side_r[SIDE_DIVQ].vz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= absx * quo;
      pz_r   <= absz * quo;
      negx_r <= side_r[SIDE_DIVQ].vx > 32'sd0;
      negz_r <= side_r[SIDE_DIVQ].vz > 32'sd0;
    end
  end

  // final assembly; zero everything out of contact
  gcf_pkg::gcf_side_t last;
  gcf_pkg::gcf_out_t  out_nxt;

  always_comb begin
    last    = side_r[SIDE_LEN-1];
    out_nxt = '0;
    if (last.contact) begin
      out_nxt.contact  = 1'b1;
      out_nxt.depth    = last.depth;
      out_nxt.force_y  = last.fn;
      out_nxt.torque_x = last.tq_x;
      out_nxt.torque_y = last.tq_y;
      out_nxt.torque_z = last.tq_z;
      if (last.fric_en) begin
        out_nxt.force_x = gcf_pkg::opp_sat(negx_r, {2'd0, px_r[61:16]});
        out_nxt.force_z = gcf_pkg::opp_sat(negz_r, {2'd0, pz_r[61:16]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SIDE_LEN; j++) side_r[j] <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      side_r[0] <= fr_side;
      for (int j = 1; j < SIDE_LEN; j++) side_r[j] <= side_r[j-1];
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_contact_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.contact |->
      out_data.depth == 31'd0 && out_data.force_y == 31'd0 &&
      out_data.force_x == 32'sd0 && out_data.force_z == 32'sd0 &&
      out_data.torque_x == 32'sd0 && out_data.torque_y == 32'sd0 &&
      out_data.torque_z == 32'sd0)
    else $error("nonzero result without contact");

  a_no_normal_no_friction : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.force_y == 31'd0 |->
      out_data.force_x == 32'sd0 && out_data.force_z == 32'sd0 &&
      out_data.torque_x == 32'sd0 && out_data.torque_y == 32'sd0 &&
      out_data.torque_z == 32'sd0)
    else $error("friction or torque without normal force");

  a_depth_needs_contact : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.depth != 31'd0 |-> out_data.contact)
    else $error("depth reported out of contact");

  a_stall_holds_tail : assert property (@(posedge clk) disable iff (!rst_n)
    !en && side_r[SIDE_LEN-1].valid |=> side_r[SIDE_LEN-1].valid)
    else $error("transaction dropped during stall");

endmodule

>>> dv/gcf_checker.sv
module gcf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  gcf_pkg::gcf_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  gcf_pkg::gcf_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [gcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcf_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            contacts
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  logic [gcf_pkg::CFG_W-1:0] radius_r, stiff_r, damp_r, mu_r;
  gcf_pkg::gcf_out_t         contact_q[$];

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // scale magnitude, then point against the sign of v
  function automatic wide_t against(input wide_t v, input logic [63:0] scale);
    logic [127:0] mag;
    logic [127:0] m;
    mag = (v < 0) ? -v : v;
    m = (mag * {64'd0, scale}) >> 16;
    return (v > 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic wide_t clamp_unit(input logic signed [31:0] v);
    wide_t w;
    w = v;
    if (w > 128'sd1073741824) return 128'sd1073741824;
    if (w < -128'sd1073741824) return -128'sd1073741824;
    return w;
  endfunction

  function automatic gcf_pkg::gcf_out_t contact_response(input gcf_pkg::gcf_in_t x);
    gcf_pkg::gcf_out_t res;
    wide_t    p, fnr, vx, vy, vz, one, w, qx, qy, qz, fx, fz;
    wide_t    mm[9];
    wide_t    e[9];
    wide_t    wr[3];
    wide_t    rt[3];
    logic [63:0] fn, sum, vt, coul, visc, dyn, r, rot;
    res = '0;
    vx = x.vel_x;
    vy = x.vel_y;
    vz = x.vel_z;
    rt[0] = x.rate_x;
    rt[1] = x.rate_y;
    rt[2] = x.rate_z;
    w  = clamp_unit(x.quat_w);
    qx = clamp_unit(x.quat_x);
    qy = clamp_unit(x.quat_y);
    qz = clamp_unit(x.quat_z);
    p = wide_t'(x.ground_height) + wide_t'({1'b0, radius_r}) - wide_t'(x.height);
    if (p * 100 < -128'sd32768) return res;
    res.contact = 1'b1;
    res.depth = (p < 0) ? '0 : (p > 128'sd2147483647) ? 31'h7fffffff : p[30:0];
    fnr = (wide_t'({1'b0, stiff_r}) * p - wide_t'({1'b0, damp_r}) * vy) >>> 16;
    if (fnr < 0) fn = 0;
    else if (fnr > 128'sd2147483647) fn = 64'd2147483647;
    else fn = fnr[63:0];
    res.force_y = fn[30:0];
    fx = 0;
    fz = 0;
    sum = 64'(vx * vx + vz * vz);
    if (sum != 0 && fn != 0) begin
      vt   = root_floor(sum);
      coul = ({33'd0, mu_r} * fn) >> 16;
      visc = ({33'd0, damp_r} * vt) >> 17;
      dyn  = (coul < visc) ? coul : visc;
      r    = (dyn << 16) / vt;
      fx   = against(vx, r);
      fz   = against(vz, r);
    end
    res.force_x = sat32(fx);
    res.force_z = sat32(fz);
    one = 128'sd1 <<< 60;
    mm[0] = one - 2 * (qy * qy + qz * qz);
    mm[1] = 2 * (qx * qy - w * qz);
    mm[2] = 2 * (qx * qz + w * qy);
    mm[3] = 2 * (qx * qy + w * qz);
    mm[4] = one - 2 * (qx * qx + qz * qz);
    mm[5] = 2 * (qy * qz - w * qx);
    mm[6] = 2 * (qx * qz - w * qy);
    mm[7] = 2 * (qy * qz + w * qx);
    mm[8] = one - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 9; i++) begin
      e[i] = mm[i] >>> 30;
      if (e[i] > 128'sd1073741824) e[i] = 128'sd1073741824;
      if (e[i] < -128'sd1073741824) e[i] = -128'sd1073741824;
    end
    for (int i = 0; i < 3; i++)
      wr[i] = (e[3*i] * rt[0] + e[3*i+1] * rt[1] + e[3*i+2] * rt[2]) >>> 30;
    rot = (fn * 64'd214748365) >> 32;
    res.torque_x = sat32(against(wr[0], rot));
    res.torque_y = sat32(against(wr[1], rot));
    res.torque_z = sat32(against(wr[2], rot));
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gcf_pkg::gcf_out_t exp_r;
    if (!rst_n) begin
      radius_r <= '0;
      stiff_r  <= '0;
      damp_r   <= '0;
      mu_r     <= '0;
      contact_q.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      contacts   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gcf_pkg::CFG_RADIUS:   radius_r <= cfg_wdata;
          gcf_pkg::CFG_STIFF:    stiff_r  <= cfg_wdata;
          gcf_pkg::CFG_DAMP:     damp_r   <= cfg_wdata;
          gcf_pkg::CFG_FRICTION: mu_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) contact_q.push_back(contact_response(in_data));
      if (out_valid && out_ready) begin
        if (contact_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          exp_r = contact_q.pop_front();
          check_field("contact", 32'(exp_r.contact), 32'(out_data.contact));
          check_field("depth", 32'(exp_r.depth), 32'(out_data.depth));
          check_field("force_x", exp_r.force_x, out_data.force_x);
          check_field("force_y", 32'(exp_r.force_y), 32'(out_data.force_y));
          check_field("force_z", exp_r.force_z, out_data.force_z);
          check_field("torque_x", exp_r.torque_x, out_data.torque_x);
          check_field("torque_y", exp_r.torque_y, out_data.torque_y);
          check_field("torque_z", exp_r.torque_z, out_data.torque_z);
          checked++;
          if (exp_r.contact) contacts++;
        end
      end
      pending = contact_q.size();
    end
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 1350;
  localparam int N_PHASES   = 6;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  gcf_pkg::gcf_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  gcf_pkg::gcf_out_t             out_data;
  logic                          cfg_we = 1'b0;
  logic [gcf_pkg::CFG_IDX_W-1:0] cfg_index = gcf_pkg::CFG_RADIUS;
  logic [gcf_pkg::CFG_W-1:0]     cfg_wdata = '0;

  int fail_count, pending, checked, contacts;
  int idle_cycles = 0;
  int sent = 0;
  bit hold_off = 1'b0;
  logic [gcf_pkg::CFG_W-1:0] radius_now = '0;

  always #4 clk = ~clk;

  ground_contact_force_core i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  gcf_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending, .checked, .contacts
  );

  // receiver: stall pattern drawn at random from four modes; one long hold-off
  always @(posedge clk) begin
    static int cyc = 0;
    static int mode = 0;
    static int hold_cnt = 0;
    cyc++;
    if (cyc % 256 == 0) mode = $urandom_range(0, 3);
    if (hold_off && hold_cnt < 400) begin
      hold_cnt++;
      out_ready <= 1'b0;
    end else begin
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= ($urandom_range(0, 9) < 3);
        default: out_ready <= cyc[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
      2: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      3: return '0;
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
    endcase
  endfunction

  function automatic logic [31:0] pick_quat();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2:    return $urandom_range(0, 1) ? gcf_pkg::ONE_Q30 : gcf_pkg::NEG_ONE_Q30;
      default: return 32'($signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000);
    endcase
  endfunction

  function automatic gcf_pkg::gcf_in_t random_body();
    gcf_pkg::gcf_in_t b;
    logic signed [31:0] pen;
    b.vel_x  = pick_value();
    b.vel_y  = pick_value();
    b.vel_z  = pick_value();
    b.rate_x = pick_value();
    b.rate_y = pick_value();
    b.rate_z = pick_value();
    b.quat_w = pick_quat();
    b.quat_x = pick_quat();
    b.quat_y = pick_quat();
    b.quat_z = pick_quat();
    b.ground_height = pick_value();
    // mostly place the body near the ground so contact is frequent
    if ($urandom_range(0, 9) < 8) begin
      pen = 32'($signed($urandom_range(0, 32'h40000)) - 32'sh2000);
      b.height = b.ground_height + $signed({1'b0, radius_now}) - pen;
    end else begin
      b.height = pick_value();
    end
    return b;
  endfunction

  task automatic send_body(input gcf_pkg::gcf_in_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [gcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcf_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == gcf_pkg::CFG_RADIUS) radius_now = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic directed_bodies();
    gcf_pkg::gcf_in_t b;
    b = '0;
    b.quat_w = gcf_pkg::ONE_Q30;
    send_body(b);                               // resting exactly on ground at zero radius
    b.height = 32'sd327;                        // just inside tolerance band at zero radius
    send_body(b);
    b.height = 32'sd328;                        // just outside: no contact at zero radius
    send_body(b);
    b.height = -32'sd65536;
    b.vel_y = -32'sd65536;
    b.vel_x = 32'sd131072;
    b.vel_z = -32'sd65536;
    b.rate_x = 32'sd65536;
    b.rate_y = -32'sd131072;
    b.rate_z = 32'sd65536;
    send_body(b);
    b.vel_x = 0;
    b.vel_z = 0;                                // no planar speed: no friction
    send_body(b);
    b.quat_w = 32'sh7fffffff;                   // out-of-range quaternion saturates
    b.quat_x = 32'sh80000000;
    b.quat_y = 32'sh7fffffff;
    b.quat_z = 32'sh80000000;
    send_body(b);
    b.quat_w = 32'sh20000000;                   // non-unit quaternion as given
    b.quat_x = 32'sh10000000;
    b.quat_y = 0;
    b.quat_z = 0;
    send_body(b);
    b = '{default: 32'sh7fffffff};
    send_body(b);
    b = '{default: 32'sh80000000};
    send_body(b);
    b.height = 32'sh80000000;
    b.ground_height = 32'sh7fffffff;            // deepest penetration
    b.vel_y = 32'sh80000000;
    send_body(b);
    b.vel_y = 32'sh7fffffff;                    // damping can clamp the normal force at zero
    send_body(b);
    b = '{default: 32'hffffffff};
    send_body(b);
  endtask

  initial begin
    int burst, gap, done;
    logic [gcf_pkg::CFG_W-1:0] cfg_set[N_PHASES][4];
    cfg_set[0] = '{31'h8000, 31'd65536000, 31'd3276800, 31'h8000};
    cfg_set[1] = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
    cfg_set[2] = '{31'd0, 31'd0, 31'd0, 31'd0};
    cfg_set[3] = '{31'd0, 31'h7fffffff, 31'd0, 31'h7fffffff};
    cfg_set[4] = '{31'h1000, 31'd6553600, 31'h7fffffff, 31'h10000};
    cfg_set[5] = '{gcf_pkg::CFG_W'($urandom()), gcf_pkg::CFG_W'($urandom()),
                   gcf_pkg::CFG_W'($urandom()), gcf_pkg::CFG_W'($urandom())};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_bodies();
    drain();
    done = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(gcf_pkg::CFG_IDX_W'(r), cfg_set[ph][r]);
      cfg_we <= 1'b0;
      if (ph == 0 || ph == 4) directed_bodies();
      if (ph == 2) hold_off = 1'b1;
      while (done < RAND_ITEMS * (ph + 1) / N_PHASES) begin
        burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          send_body(random_body());
          done++;
        end
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d bodies over %0d register settings; %0d results checked, %0d in contact",
             sent, N_PHASES, checked, contacts);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
